### design/usq_pkg.sv
// usq_pkg: shared constants, types and helpers for the URL query secret masker.
// Used by usq_cell, usq_match and the masker; depends on nothing.
`default_nettype none
package usq_pkg;

  typedef logic [7:0] byte_t;

  localparam int WIN_DEPTH    = 7;
  localparam int NEEDLE_COUNT = 8;
  localparam int NEEDLE_MAX   = 8;

  // phase codes
  localparam logic [1:0] PH_PATH  = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam byte_t CH_MASK  = 8'h2A;  // '*'
  localparam byte_t CH_QUERY = 8'h3F;  // '?'
  localparam byte_t CH_EQ    = 8'h3D;  // '='
  localparam byte_t CH_AMP   = 8'h26;  // '&'
  localparam byte_t CH_SEMI  = 8'h3B;  // ';'

  // Right-justified: the byte at [b*8 +: 8] sits b places back from the last byte.
  localparam logic [NEEDLE_MAX*8-1:0] NEEDLE_TEXT [NEEDLE_COUNT] = '{
    64'("token"), 64'("sig"), 64'("password"), 64'("passwd"),
    64'("secret"), 64'("key"), 64'("code"), 64'("auth")
  };
  localparam int NEEDLE_LEN [NEEDLE_COUNT] = '{5, 3, 8, 6, 6, 3, 4, 4};

  typedef byte_t win_t [WIN_DEPTH];

  // per-cycle control for the window cells
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic byte_t fold_lower(input byte_t c);
    return (c >= 8'h41 && c <= 8'h5A) ? byte_t'(c + 8'h20) : c;
  endfunction

endpackage
`default_nettype wire

### design/usq_in_if.sv
// usq_in_if: input byte channel (valid/ready plus URL byte and last flag).
// No dependencies.
`default_nettype none
interface usq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface
`default_nettype wire

### design/usq_out_if.sv
// usq_out_if: result channel (valid/ready plus masked byte and status flags).
// No dependencies.
`default_nettype none
interface usq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       leak_found;
  logic       end_of_url;

  modport source (output valid, output out_byte, output leak_found, output end_of_url,
                  input ready);
  modport sink   (input valid, input out_byte, input leak_found, input end_of_url,
                  output ready);
endinterface
`default_nettype wire

### design/usq_cell.sv
// usq_cell: one stage of the key window, a folded key byte plus a valid bit.
// Depends on usq_pkg.
`default_nettype none
module usq_cell (
  input  wire               clk,
  input  wire               rst_n,
  input  usq_pkg::cell_ctl_t ctl,
  input  usq_pkg::byte_t    d_in,
  input  wire               v_in,
  output usq_pkg::byte_t    q,
  output logic              v
);
  import usq_pkg::*;

  byte_t q_r;
  logic  v_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      q_r <= '0;
      v_r <= 1'b0;
    end else if (ctl.shift) begin
      q_r <= d_in;
      v_r <= v_in;
    end
  end

  assign q = q_r;
  assign v = v_r;
endmodule
`default_nettype wire

### design/usq_match.sv
// usq_match: parallel needle compare of the current byte against the cell row.
// Depends on usq_pkg.
`default_nettype none
module usq_match (
  input  usq_pkg::byte_t cur,
  input  usq_pkg::win_t  win,
  input  wire [usq_pkg::WIN_DEPTH-1:0] win_v,
  output logic           hit
);
  import usq_pkg::*;

  logic [NEEDLE_MAX-1:0]   char_ok [NEEDLE_COUNT];
  logic [NEEDLE_COUNT-1:0] needle_ok;

  for (genvar k = 0; k < NEEDLE_COUNT; k++) begin : g_needle
    for (genvar b = 0; b < NEEDLE_MAX; b++) begin : g_char
      if (b >= NEEDLE_LEN[k]) begin : g_unused
        assign char_ok[k][b] = 1'b1;
      end else if (b == 0) begin : g_cur
        assign char_ok[k][b] = (cur == NEEDLE_TEXT[k][b*8 +: 8]);
      end else begin : g_win
        // b places back lives in cell b-1
        assign char_ok[k][b] = win_v[b-1] && (win[b-1] == NEEDLE_TEXT[k][b*8 +: 8]);
      end
    end
    assign needle_ok[k] = &char_ok[k];
  end

  assign hit = |needle_ok;
endmodule
`default_nettype wire

### design/url_query_secret_masker.sv
// url_query_secret_masker: an accepted byte's result is valid in the next cycle.
// Throughput 1 byte per cycle while the output is taken; the key window compare is
// one parallel pass over the cell row, and the output register frees as it is taken.
// Reset (rst_n low, synchronous): path phase, window cells cleared, flags zero,
// no result pending. State also returns to reset after a byte flagged last.
`default_nettype none
module url_query_secret_masker (
  input  wire        clk,
  input  wire        rst_n,
  usq_in_if.sink     in_ch,
  usq_out_if.source  out_ch
);
  import usq_pkg::*;

  // ---------------- control state ----------------
  logic [1:0] phase_r, phase_nxt;
  logic       matched_r, matched_nxt;   // needle seen in current key
  logic       mask_r, mask_nxt;         // current value belongs to a secret key
  logic       leak_r, leak_nxt;         // sticky leak flag for this URL

  // output register
  logic  out_valid_r;
  byte_t out_byte_r, out_byte_nxt;
  logic  out_leak_r;
  logic  out_eou_r;

  // A new byte is taken whenever the output slot is empty or being drained.
  logic acc;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  // ---------------- key window: chain of cells ----------------
  byte_t               cur;
  win_t                win;
  logic [WIN_DEPTH-1:0] win_v;
  cell_ctl_t           ctl;
  logic                push_c, clear_c, hit;

  assign cur = fold_lower(in_ch.in_byte);

  // cell 0 takes the new folded byte, each later cell its left neighbor
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      usq_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .d_in (cur),
        .v_in (1'b1),
        .q    (win[i]),
        .v    (win_v[i])
      );
    end else begin : g_body
      usq_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .d_in (win[i-1]),
        .v_in (win_v[i-1]),
        .q    (win[i]),
        .v    (win_v[i])
      );
    end
  end

  usq_match u_match (
    .cur  (cur),
    .win  (win),
    .win_v(win_v),
    .hit  (hit)
  );

  // ---------------- phase logic ----------------
  logic is_sep;
  assign is_sep = (in_ch.in_byte == CH_AMP) || (in_ch.in_byte == CH_SEMI);

  always_comb begin
    phase_nxt    = phase_r;
    matched_nxt  = matched_r;
    mask_nxt     = mask_r;
    leak_nxt     = leak_r;
    out_byte_nxt = in_ch.in_byte;
    push_c       = 1'b0;
    clear_c      = 1'b0;

    unique case (phase_r)
      PH_KEY: begin
        if (in_ch.in_byte == CH_EQ) begin
          mask_nxt  = matched_r;
          leak_nxt  = leak_r | matched_r;
          phase_nxt = PH_VALUE;
        end else if (is_sep) begin
          clear_c     = 1'b1;
          matched_nxt = 1'b0;
        end else begin
          push_c      = 1'b1;
          matched_nxt = matched_r | hit;
        end
      end
      PH_VALUE: begin
        if (is_sep) begin
          // separator ending a value passes unchanged
          clear_c     = 1'b1;
          matched_nxt = 1'b0;
          mask_nxt    = 1'b0;
          phase_nxt   = PH_KEY;
        end else if (mask_r) begin
          out_byte_nxt = CH_MASK;
        end
      end
      default: begin
        // path phase; the unused code behaves the same
        if (in_ch.in_byte == CH_QUERY) begin
          clear_c     = 1'b1;
          matched_nxt = 1'b0;
          phase_nxt   = PH_KEY;
        end
      end
    endcase
  end

  // last byte wipes the window along with everything else
  assign ctl.clear = acc && (clear_c || in_ch.last);
  assign ctl.shift = acc && push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PATH;
      matched_r <= 1'b0;
      mask_r    <= 1'b0;
      leak_r    <= 1'b0;
    end else if (acc) begin
      if (in_ch.last) begin
        phase_r   <= PH_PATH;
        matched_r <= 1'b0;
        mask_r    <= 1'b0;
        leak_r    <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        matched_r <= matched_nxt;
        mask_r    <= mask_nxt;
        leak_r    <= leak_nxt;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_byte_r <= out_byte_nxt;
      out_leak_r <= leak_nxt;     // flag counts the current byte
      out_eou_r  <= in_ch.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.leak_found = out_leak_r;
  assign out_ch.end_of_url = out_eou_r;

`ifndef NO_ASSERTIONS
  // end of URL brings the control state back to its reset values
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.last) |=> (phase_r == PH_PATH && !leak_r && !mask_r && win_v == '0))
    else $error("state not cleared after last byte");

  // the leak flag can only be up inside the query part
  a_leak_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    leak_r |-> (phase_r == PH_KEY || phase_r == PH_VALUE))
    else $error("leak flag set outside query");

  // a masked value byte comes out as the mask character
  a_mask_out: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_VALUE && mask_r && !is_sep) |=> (out_byte_r == CH_MASK))
    else $error("secret value byte not masked");

  // masking implies a leak was recorded
  a_mask_leak: assert property (@(posedge clk) disable iff (!rst_n)
    mask_r |-> leak_r)
    else $error("masking without leak flag");
`endif

endmodule
`default_nettype wire
